FILE: hdl/blhg_pkg.sv
// Shared constants, types and level classifiers for the battery level gauge.
`timescale 1ns / 1ps

package blhg_pkg;

    localparam int unsigned MV_W     = 16;
    localparam int unsigned LEVEL_W  = 3;
    localparam int unsigned STEP_W   = 16;
    localparam int unsigned FULL_W   = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [MV_W-1:0]    mv_t;

    localparam level_t LEVEL_TOP = 3'd5;

    localparam logic [STEP_W-1:0] STEP_MAX = 16'hFFFF;

    localparam logic [STEP_W-1:0] STEP_TICKS_RST       = 16'd1000;
    localparam logic [FULL_W-1:0] FORCE_FULL_TICKS_RST = 24'd240000;
    localparam mv_t               FORCE_FULL_MV_RST    = 16'd8360;

    localparam mv_t DIS_HI5   = 16'd6800;
    localparam mv_t DIS_HOLD5 = 16'd6700;
    localparam mv_t DIS_HI4   = 16'd6400;
    localparam mv_t DIS_HOLD4 = 16'd6300;
    localparam mv_t DIS_HI3   = 16'd6100;
    localparam mv_t DIS_HOLD3 = 16'd6000;
    localparam mv_t DIS_HI2   = 16'd5900;
    localparam mv_t DIS_HOLD2 = 16'd5800;
    localparam mv_t DIS_HI1   = 16'd5600;
    localparam mv_t CHG_HI5   = 16'd8300;
    localparam mv_t CHG_HOLD5 = 16'd8200;
    localparam mv_t CHG_HI4   = 16'd8200;
    localparam mv_t CHG_HOLD4 = 16'd8100;
    localparam mv_t CHG_HI3   = 16'd7800;
    localparam mv_t CHG_HOLD3 = 16'd7700;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_TICKS       = 2'd0,
        CFG_FORCE_FULL_TICKS = 2'd1,
        CFG_FORCE_FULL_MV    = 2'd2
    } cfg_idx_t;

    function automatic level_t classify_discharge(input mv_t mv, input level_t prev);
        level_t lvl;
        if (mv > DIS_HI5)                              lvl = 3'd5;
        else if (mv > DIS_HOLD5 && prev == 3'd5)       lvl = 3'd5;
        else if (mv > DIS_HI4)                         lvl = 3'd4;
        else if (mv > DIS_HOLD4 && prev == 3'd4)       lvl = 3'd4;
        else if (mv > DIS_HI3)                         lvl = 3'd3;
        else if (mv > DIS_HOLD3 && prev == 3'd3)       lvl = 3'd3;
        else if (mv > DIS_HI2)                         lvl = 3'd2;
        else if (mv > DIS_HOLD2 && prev == 3'd2)       lvl = 3'd2;
        else if (mv > DIS_HI1)                         lvl = 3'd1;
        else                                           lvl = 3'd0;
        return lvl;
    endfunction

    function automatic level_t classify_charge(input mv_t mv, input level_t prev);
        level_t lvl;
        if (mv > CHG_HI5)                              lvl = 3'd5;
        else if (mv > CHG_HOLD5 && prev == 3'd5)       lvl = 3'd5;
        else if (mv > CHG_HI4)                         lvl = 3'd4;
        else if (mv > CHG_HOLD4 && prev == 3'd4)       lvl = 3'd4;
        else if (mv > CHG_HI3)                         lvl = 3'd3;
        else if (mv > CHG_HOLD3 && prev == 3'd3)       lvl = 3'd3;
        else                                           lvl = 3'd1;
        return lvl;
    endfunction

endpackage

FILE: hdl/battery_level_hysteresis_gauge_core.sv
// Battery level gauge top level: classifier, display slew and forced-full timer.
// The result is registered and valid in the cycle after its input transfer.
// Throughput: one item per cycle; the result register stalls input only while
// a result waits and out_ready is low.
// Reset: levels and counters clear to zero, registers take their default values.
`timescale 1ns / 1ps

module battery_level_hysteresis_gauge_core
    import blhg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MV_W-1:0]       pack_mv,
    input  logic                  charging,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LEVEL_W-1:0]    level_now,
    output logic [LEVEL_W-1:0]    level_shown
);

    logic [STEP_W-1:0] step_ticks_reg;
    logic [FULL_W-1:0] force_full_ticks_reg;
    mv_t               force_full_mv_reg;

    level_t            cur_level_reg,   cur_level_next;
    level_t            shown_level_reg, shown_level_next;
    logic [STEP_W-1:0] step_count_reg,  step_count_next;
    logic [FULL_W-1:0] full_count_reg,  full_count_next;
    logic              out_valid_reg,   out_valid_next;

    logic              in_fire;
    logic              moving;
    logic [STEP_W-1:0] step_inc;
    logic [FULL_W:0]   full_inc;

    assign in_ready    = !out_valid_reg || out_ready;
    assign in_fire     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign level_now   = cur_level_reg;
    assign level_shown = shown_level_reg;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ticks_reg       <= STEP_TICKS_RST;
            force_full_ticks_reg <= FORCE_FULL_TICKS_RST;
            force_full_mv_reg    <= FORCE_FULL_MV_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_TICKS:       step_ticks_reg       <= cfg_data[STEP_W-1:0];
                CFG_FORCE_FULL_TICKS: force_full_ticks_reg <= cfg_data[FULL_W-1:0];
                CFG_FORCE_FULL_MV:    force_full_mv_reg    <= cfg_data[MV_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        cur_level_next   = cur_level_reg;
        shown_level_next = shown_level_reg;
        step_count_next  = step_count_reg;
        full_count_next  = full_count_reg;
        out_valid_next   = out_valid_reg;
        moving           = 1'b0;
        step_inc         = (step_count_reg == STEP_MAX) ? step_count_reg
                                                        : step_count_reg + 1'b1;
        full_inc         = {1'b0, full_count_reg} + 1'b1;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            out_valid_next = 1'b1;
            if (!charging)
            begin
                cur_level_next  = classify_discharge(pack_mv, cur_level_reg);
                moving          = cur_level_next < shown_level_reg;
                full_count_next = '0;
            end
            else
            begin
                cur_level_next = classify_charge(pack_mv, cur_level_reg);
                moving         = cur_level_next > shown_level_reg;
            end

            // Slew the display one level after the difference outlasts step_ticks
            if (moving)
            begin
                if (step_inc > step_ticks_reg)
                begin
                    step_count_next = '0;
                    if (!charging && shown_level_reg != '0)
                    begin
                        shown_level_next = shown_level_reg - 1'b1;
                    end
                    else if (charging && shown_level_reg < LEVEL_TOP)
                    begin
                        shown_level_next = shown_level_reg + 1'b1;
                    end
                end
                else
                begin
                    step_count_next = step_inc;
                end
            end
            else
            begin
                step_count_next = '0;
            end

            // Advance the forced-full timer, clamp and force the top level
            if (charging && pack_mv > force_full_mv_reg)
            begin
                if (full_inc >= {1'b0, force_full_ticks_reg})
                begin
                    full_count_next  = force_full_ticks_reg;
                    shown_level_next = LEVEL_TOP;
                end
                else
                begin
                    full_count_next = full_inc[FULL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_level_reg   <= '0;
            shown_level_reg <= '0;
            step_count_reg  <= '0;
            full_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_level_reg   <= cur_level_next;
            shown_level_reg <= shown_level_next;
            step_count_reg  <= step_count_next;
            full_count_reg  <= full_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_level_reg <= LEVEL_TOP && shown_level_reg <= LEVEL_TOP)
        else $error("level register above top level");

    a_timer_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !charging |=> full_count_reg == '0)
        else $error("forced-full timer not cleared while discharging");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(shown_level_reg) && $stable(cur_level_reg)
                     && $stable(step_count_reg))
        else $error("gauge state changed without an input transfer");

    a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> shown_level_reg == $past(shown_level_reg)
                 || shown_level_reg == $past(shown_level_reg) + 3'd1
                 || shown_level_reg + 3'd1 == $past(shown_level_reg)
                 || shown_level_reg == LEVEL_TOP)
        else $error("display moved more than one level");

    a_result_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("no result after input transfer");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the battery level hysteresis gauge core.
`timescale 1ns / 1ps

module tb_top
    import blhg_pkg::*;
;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_TICKS   = 125;

    typedef struct packed {
        level_t now;
        level_t shown;
    } gauge_levels_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [MV_W-1:0]       pack_mv;
    logic                  charging;
    logic                  out_valid;
    logic                  out_ready;
    logic [LEVEL_W-1:0]    level_now;
    logic [LEVEL_W-1:0]    level_shown;

    battery_level_hysteresis_gauge_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pack_mv    (pack_mv),
        .charging   (charging),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .level_now  (level_now),
        .level_shown(level_shown)
    );

    gauge_levels_t     expected_levels[$];
    logic [STEP_W-1:0] step_limit = STEP_TICKS_RST;
    logic [FULL_W-1:0] full_limit = FORCE_FULL_TICKS_RST;
    mv_t               full_mv    = FORCE_FULL_MV_RST;
    level_t            cur_lvl    = '0;
    level_t            shown_lvl  = '0;
    logic [STEP_W-1:0] step_cnt   = '0;
    int unsigned       full_cnt   = 0;

    bit steady = 1'b0;
    int mismatches = 0;
    int ticks_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = steady || ($urandom_range(99) >= 24);
        end
    end

    function automatic level_t discharge_plain(input mv_t mv);
        if (mv > DIS_HI5) return 3'd5;
        if (mv > DIS_HI4) return 3'd4;
        if (mv > DIS_HI3) return 3'd3;
        if (mv > DIS_HI2) return 3'd2;
        if (mv > DIS_HI1) return 3'd1;
        return 3'd0;
    endfunction

    function automatic mv_t discharge_keep(input level_t prev);
        case (prev)
            3'd5:    return DIS_HOLD5;
            3'd4:    return DIS_HOLD4;
            3'd3:    return DIS_HOLD3;
            3'd2:    return DIS_HOLD2;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic level_t charge_plain(input mv_t mv);
        if (mv > CHG_HI5) return 3'd5;
        if (mv > CHG_HI4) return 3'd4;
        if (mv > CHG_HI3) return 3'd3;
        return 3'd1;
    endfunction

    function automatic mv_t charge_keep(input level_t prev);
        case (prev)
            3'd5:    return CHG_HOLD5;
            3'd4:    return CHG_HOLD4;
            3'd3:    return CHG_HOLD3;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic gauge_predict(input mv_t mv, input logic chg);
        level_t        plain;
        gauge_levels_t res;
        // hold the previous level inside its hysteresis band
        if (chg)
        begin
            plain = charge_plain(mv);
            if (plain < cur_lvl && mv > charge_keep(cur_lvl))
                plain = cur_lvl;
        end
        else
        begin
            plain = discharge_plain(mv);
            if (plain < cur_lvl && mv > discharge_keep(cur_lvl))
                plain = cur_lvl;
        end
        cur_lvl = plain;
        if (chg ? (cur_lvl > shown_lvl) : (cur_lvl < shown_lvl))
        begin
            if (step_cnt != STEP_MAX)
                step_cnt = step_cnt + 1'b1;
            if (step_cnt > step_limit)
            begin
                step_cnt  = '0;
                shown_lvl = chg ? shown_lvl + 1'b1 : shown_lvl - 1'b1;
            end
        end
        else
            step_cnt = '0;
        if (!chg)
            full_cnt = 0;
        else if (mv > full_mv)
        begin
            full_cnt = full_cnt + 1;
            if (full_cnt >= 32'(full_limit))
            begin
                full_cnt  = 32'(full_limit);
                shown_lvl = LEVEL_TOP;
            end
        end
        res.now   = cur_lvl;
        res.shown = shown_lvl;
        expected_levels.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        gauge_levels_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_levels.size() == 0)
                report_mismatch("unexpected result, level_now", int'(level_now), -1);
            else
            begin
                want = expected_levels.pop_front();
                if (level_now !== want.now)
                    report_mismatch("level_now", int'(level_now), int'(want.now));
                if (level_shown !== want.shown)
                    report_mismatch("level_shown", int'(level_shown), int'(want.shown));
                results_checked++;
            end
        end
    end

    task automatic drive_tick(input mv_t mv, input logic chg);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 24)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        pack_mv  = mv;
        charging = chg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gauge_predict(mv, chg);
        ticks_sent++;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_levels.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        in_valid  = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_STEP_TICKS:       step_limit = val[STEP_W-1:0];
            CFG_FORCE_FULL_TICKS: full_limit = val[FULL_W-1:0];
            CFG_FORCE_FULL_MV:    full_mv    = val[MV_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic test_reset_defaults();
        drive_tick(16'd0, 1'b0);
        drive_tick(16'hFFFF, 1'b1);
        drive_tick(16'hFFFF, 1'b0);
        drive_tick(CHG_HI5, 1'b1);
        wait_drain();
    endtask

    task automatic test_single_step_slew();
        cfg_write(CFG_IDX_NONE, 24'hFFFFFF);
        cfg_write(CFG_STEP_TICKS, 24'd0);
        cfg_write(CFG_FORCE_FULL_TICKS, 24'hFFFFFF);
        cfg_write(CFG_FORCE_FULL_MV, 24'h00FFFF);
        repeat (4) drive_tick(16'hFFFF, 1'b1);
        repeat (4) drive_tick(16'd0, 1'b0);
        wait_drain();
    endtask

    task automatic test_full_timer_clamp();
        cfg_write(CFG_STEP_TICKS, 24'h00FFFF);
        cfg_write(CFG_FORCE_FULL_TICKS, 24'd20);
        cfg_write(CFG_FORCE_FULL_MV, 24'd8000);
        repeat (6) drive_tick(16'd9000, 1'b1);
        wait_drain();
        // lower the limit below the running timer
        cfg_write(CFG_FORCE_FULL_TICKS, 24'd3);
        drive_tick(16'd9000, 1'b1);
        wait_drain();
    endtask

    task automatic test_force_at_zero();
        cfg_write(CFG_STEP_TICKS, 24'd0);
        repeat (3) drive_tick(16'd0, 1'b0);
        wait_drain();
        cfg_write(CFG_FORCE_FULL_TICKS, 24'd0);
        cfg_write(CFG_FORCE_FULL_MV, 24'd0);
        drive_tick(16'd1, 1'b1);
        drive_tick(16'd0, 1'b1);
        wait_drain();
    endtask

    function automatic int ladder_mv(input logic chg);
        int k;
        k = $urandom_range(0, 9);
        if (chg)
        begin
            case (k % 7)
                0:       return int'(CHG_HI5);
                1:       return int'(CHG_HOLD5);
                2:       return int'(CHG_HOLD4);
                3:       return int'(CHG_HI3);
                4:       return int'(CHG_HOLD3);
                default: return int'(full_mv);
            endcase
        end
        case (k)
            0:       return int'(DIS_HI5);
            1:       return int'(DIS_HOLD5);
            2:       return int'(DIS_HI4);
            3:       return int'(DIS_HOLD4);
            4:       return int'(DIS_HI3);
            5:       return int'(DIS_HOLD3);
            6:       return int'(DIS_HI2);
            7:       return int'(DIS_HOLD2);
            8:       return int'(DIS_HI1);
            default: return int'(full_mv);
        endcase
    endfunction

    task automatic test_random_phases();
        int   run_left;
        int   walk_mv;
        int   v;
        int   sel;
        logic chg;
        run_left = 0;
        walk_mv  = 6000;
        chg      = 1'b0;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drain();
            case (p)
                0:
                begin
                    cfg_write(CFG_STEP_TICKS, 24'd0);
                    cfg_write(CFG_FORCE_FULL_TICKS, 24'd1);
                    cfg_write(CFG_FORCE_FULL_MV, 24'd0);
                end
                1:
                begin
                    cfg_write(CFG_STEP_TICKS, 24'hFFFFFF);
                    cfg_write(CFG_FORCE_FULL_TICKS, 24'hFFFFFF);
                    cfg_write(CFG_FORCE_FULL_MV, 24'hFFFFFF);
                end
                2:
                begin
                    cfg_write(CFG_STEP_TICKS, 24'(STEP_TICKS_RST));
                    cfg_write(CFG_FORCE_FULL_TICKS, FORCE_FULL_TICKS_RST);
                    cfg_write(CFG_FORCE_FULL_MV, 24'(FORCE_FULL_MV_RST));
                end
                3:
                begin
                    cfg_write(CFG_STEP_TICKS, 24'd1);
                    cfg_write(CFG_FORCE_FULL_TICKS, 24'd0);
                    cfg_write(CFG_FORCE_FULL_MV, 24'd8000);
                end
                default:
                begin
                    cfg_write(CFG_STEP_TICKS, 24'($urandom_range(0, 12)));
                    cfg_write(CFG_FORCE_FULL_TICKS, 24'($urandom_range(0, 80)));
                    cfg_write(CFG_FORCE_FULL_MV, 24'($urandom_range(7700, 8600)));
                end
            endcase
            cfg_write(CFG_IDX_NONE, 24'($urandom_range(0, 24'hFFFFFF)));
            steady = (p == 5 || p == 6);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (run_left == 0)
                begin
                    chg      = 1'($urandom_range(0, 1));
                    run_left = $urandom_range(8, 60);
                    walk_mv  = chg ? $urandom_range(7600, 8500) : $urandom_range(5500, 6900);
                end
                run_left--;
                sel = $urandom_range(99);
                if (sel < 12)
                    drive_tick(mv_t'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
                else if (sel < 27)
                begin
                    v = ladder_mv(chg) - 1 + int'($urandom_range(0, 2));
                    v = (v < 0) ? 0 : (v > 16'hFFFF) ? 16'hFFFF : v;
                    drive_tick(mv_t'(v), chg);
                end
                else
                begin
                    walk_mv = walk_mv + int'($urandom_range(0, 300)) - 150;
                    if (chg)
                        walk_mv = (walk_mv < 7500) ? 7500 : (walk_mv > 8600) ? 8600 : walk_mv;
                    else
                        walk_mv = (walk_mv < 5400) ? 5400 : (walk_mv > 7000) ? 7000 : walk_mv;
                    drive_tick(mv_t'(walk_mv), chg);
                end
            end
            steady = 1'b0;
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pack_mv   = '0;
        charging  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_single_step_slew();
        test_full_timer_clamp();
        test_force_at_zero();
        test_random_phases();

        repeat (4) @(posedge clk);
        $display("checked %0d gauge results from %0d ticks across %0d register writes",
                 results_checked, ticks_sent, cfg_writes);
        $display("swept both ladders, slew limits 0 to 65535 and full timer limits 0 to max");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", expected_levels.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
